/* rtl/bilinear_image_downscaler_unit_defines.svh */
// assertion macros used by the downscaler sequencer
`ifndef BILINEAR_IMAGE_DOWNSCALER_UNIT_DEFINES_SVH
`define BILINEAR_IMAGE_DOWNSCALER_UNIT_DEFINES_SVH

// checked only while out of reset
`define BIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BIDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/bids_pkg.sv */
// shared constants and types of the bilinear downscaler
package bids_pkg;

  localparam int MaxSrcW     = 1024;
  localparam int SrcRowLimit = 1024;
  localparam int MaxDestDim  = 256;
  localparam int ColW        = $clog2(MaxSrcW);
  localparam int RowW        = $clog2(SrcRowLimit);
  localparam int SrcDimW     = 11;
  localparam int DstDimW     = 9;
  localparam int StepW       = 27;
  localparam int PosW        = 32;
  localparam int DColW       = 8;
  localparam int DRowW       = 9;
  localparam int IdxW        = 16;
  localparam int NormW       = 16;
  localparam int VW          = 40;
  localparam int NW          = 23;
  localparam logic [VW-1:0] NormHalf = 40'd16711680;
  localparam logic [16:0]   Recip255 = 17'd65793;
  localparam logic [16:0]   FracOne  = 17'h10000;

  typedef enum logic [2:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_DST_W  = 3'd2,
    REG_DST_H  = 3'd3,
    REG_X_STEP = 3'd4,
    REG_Y_STEP = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [SrcDimW-1:0] src_w;
    logic [SrcDimW-1:0] src_h;
    logic [DstDimW-1:0] dst_w;
    logic [DstDimW-1:0] dst_h;
    logic [StepW-1:0]   x_step;
    logic [StepW-1:0]   y_step;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic mulx;
    logic muly0;
    logic muly1;
    logic div0;
    logic div1;
  } cmd_t;

  typedef struct packed {
    logic trig;
  } sts_t;

endpackage

/* rtl/bids_pix_if.sv */
// source pixel stream channel
interface bids_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

/* rtl/bids_res_if.sv */
// destination pixel stream channel
interface bids_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_norm;
  logic [15:0] dest_index;
  logic        frame_last;
  modport source (output valid, pixel_norm, dest_index, frame_last, input ready);
  modport sink (input valid, pixel_norm, dest_index, frame_last, output ready);
endinterface

/* rtl/bilinear_image_downscaler_unit.sv */
// top level of the bilinear image downscaler
//
//  channel   dir  width  payload
//  pix_in    in   9      pixel[7:0], frame_start
//  res_out   out  33     pixel_norm[15:0], dest_index[15:0], frame_last
//  apb       in   5/32   source/dest size and Q11.16 step registers
//
// a source beat that produces no result passes through accept and store update
// a beat that produces a result passes through these steps, then waits on res_out:
//   store read, horizontal blend, two vertical multiply steps, two divide-by-255 steps
// the store write and both bank reads share one cycle, so one beat is worked at a time
// reset clears counters and handshake state; the line stores are not cleared
// no new source beat is taken until a pending result beat has left
module bilinear_image_downscaler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bids_pix_if.sink    pix_in,
  bids_res_if.source  res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bids_pkg::cfg_t cfg;
  bids_pkg::cmd_t cmd;
  bids_pkg::sts_t sts;

  // configuration registers
  bids_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: accept, step, blend, divide, hold result
  bids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .res_valid_o (res_out.valid),
    .res_ready_i (res_out.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // line stores and arithmetic
  bids_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pixel_i       (pix_in.pixel),
    .frame_start_i (pix_in.frame_start),
    .pixel_norm_o  (res_out.pixel_norm),
    .dest_index_o  (res_out.dest_index),
    .frame_last_o  (res_out.frame_last)
  );

endmodule

/* rtl/bids_regs.sv */
// apb configuration registers
module bids_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bids_pkg::cfg_t     cfg_o
);

  bids_pkg::cfg_t     cfg_q;
  bids_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = bids_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w  <= 11'd320;
      cfg_q.src_h  <= 11'd240;
      cfg_q.dst_w  <= 9'd96;
      cfg_q.dst_h  <= 9'd96;
      cfg_q.x_step <= 27'd218453;
      cfg_q.y_step <= 27'd163840;
    end else if (wr_en) begin
      case (idx)
        bids_pkg::REG_SRC_W:  cfg_q.src_w  <= pwdata[10:0];
        bids_pkg::REG_SRC_H:  cfg_q.src_h  <= pwdata[10:0];
        bids_pkg::REG_DST_W:  cfg_q.dst_w  <= pwdata[8:0];
        bids_pkg::REG_DST_H:  cfg_q.dst_h  <= pwdata[8:0];
        bids_pkg::REG_X_STEP: cfg_q.x_step <= pwdata[26:0];
        bids_pkg::REG_Y_STEP: cfg_q.y_step <= pwdata[26:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bids_pkg::REG_SRC_W:  prdata = {21'd0, cfg_q.src_w};
      bids_pkg::REG_SRC_H:  prdata = {21'd0, cfg_q.src_h};
      bids_pkg::REG_DST_W:  prdata = {23'd0, cfg_q.dst_w};
      bids_pkg::REG_DST_H:  prdata = {23'd0, cfg_q.dst_h};
      bids_pkg::REG_X_STEP: prdata = {5'd0, cfg_q.x_step};
      bids_pkg::REG_Y_STEP: prdata = {5'd0, cfg_q.y_step};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/bids_ctrl.sv */
// sequencing state machine of the downscaler
`include "bilinear_image_downscaler_unit_defines.svh"

module bids_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  input  bids_pkg::sts_t   sts_i,
  output bids_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_MULX, S_MULY0, S_MULY1, S_DIV0, S_DIV1, S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   res_valid_q;

  assign in_ready_o  = in_ready_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_valid_i && in_ready_q;
    cmd_o.step    = (state_q == S_STEP);
    cmd_o.mulx    = (state_q == S_MULX);
    cmd_o.muly0   = (state_q == S_MULY0);
    cmd_o.muly1   = (state_q == S_MULY1);
    cmd_o.div0    = (state_q == S_DIV0);
    cmd_o.div1    = (state_q == S_DIV1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_STEP;
            in_ready_q <= 1'b0;
          end
        end
        S_STEP: begin
          if (sts_i.trig) begin
            state_q <= S_MULX;
          end else begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_MULX:  state_q <= S_MULY0;
        S_MULY0: state_q <= S_MULY1;
        S_MULY1: state_q <= S_DIV0;
        S_DIV0:  state_q <= S_DIV1;
        S_DIV1: begin
          state_q     <= S_OUT;
          res_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q     <= S_IDLE;
            res_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          res_valid_q <= 1'b0;
        end
      endcase
    end
  end

  `BIDS_ASSERT(a_no_overlap, res_valid_q |-> !in_ready_q, "input taken while result pending")
  `BIDS_ASSERT(a_free_after_out, (res_valid_q && res_ready_i) |=> in_ready_q, "not ready after beat out")
  `BIDS_ASSERT(a_busy_after_in, (in_valid_i && in_ready_q) |=> (!in_ready_q && !res_valid_q), "accept did not start work")
  `BIDS_ASSERT(a_skip_no_result, (state_q == S_STEP && !sts_i.trig) |=> (in_ready_q && !res_valid_q), "idle item produced work")
  `BIDS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !res_valid_q, "result valid in reset")

endmodule

/* rtl/bids_dp.sv */
// line stores, position counters and blend arithmetic
module bids_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bids_pkg::cfg_t                cfg_i,
  input  bids_pkg::cmd_t                cmd_i,
  output bids_pkg::sts_t                sts_o,
  input  logic [7:0]                    pixel_i,
  input  logic                          frame_start_i,
  output logic [bids_pkg::NormW-1:0]    pixel_norm_o,
  output logic [bids_pkg::IdxW-1:0]     dest_index_o,
  output logic                          frame_last_o
);

  localparam int ColW  = bids_pkg::ColW;
  localparam int RowW  = bids_pkg::RowW;
  localparam int SW    = bids_pkg::SrcDimW;
  localparam int DW    = bids_pkg::DstDimW;
  localparam int PosW  = bids_pkg::PosW;
  localparam int DColW = bids_pkg::DColW;
  localparam int DRowW = bids_pkg::DRowW;
  localparam int IdxW  = bids_pkg::IdxW;
  localparam int VW    = bids_pkg::VW;
  localparam int NW    = bids_pkg::NW;

  // counters
  logic [ColW-1:0]  scol_q;
  logic [RowW-1:0]  srow_q;
  logic [DColW-1:0] dcol_q;
  logic [DRowW-1:0] drow_q;
  logic [PosW-1:0]  xpos_q, ypos_q;
  logic [IdxW-1:0]  oidx_q;
  logic             bank_q;

  // captured input
  logic [7:0] pix_q;
  logic       fs_q;

  // line stores, two banks swapped at each row end
  logic [7:0] mem0 [bids_pkg::MaxSrcW];
  logic [7:0] mem1 [bids_pkg::MaxSrcW];
  logic [7:0] rd00_q, rd01_q, rd10_q, rd11_q;

  // geometry
  logic [SW-1:0]    w, h;
  logic [DW-1:0]    dw, dh;
  logic [ColW-1:0]  scol_e, col, x0, x1;
  logic [RowW-1:0]  srow_e, row, y0, y1;
  logic [DColW-1:0] dcol_e, dcol;
  logic [DRowW-1:0] drow_e;
  logic [PosW-1:0]  xpos_e, ypos_e;
  logic [IdxW-1:0]  oidx_e;
  logic [15:0]      fx, fy;
  logic             trig, last, row_end;
  logic [PosW:0]    xsum, ysum;

  // registered per-item selects
  logic        x0_lt_q, x0_eq_q, x1_lt_q, x1_eq_q, top_up_q, bank_r_q;
  logic [15:0] fx_q, fy_q;
  logic [IdxW-1:0] idx_q;
  logic        last_q;

  // arithmetic stages
  logic [7:0]    l0, l1, u0, u1, low0, low1, top0, top1;
  logic [23:0]   t_q, b_q;
  logic [VW-1:0] p_q, v_q;
  logic [NW-1:0] n_q, n_d;
  logic [15:0]   q_q;
  logic [VW-1:0] qprod;
  logic [23:0]   r;

  // register clamping
  always_comb begin
    w  = (cfg_i.src_w == '0) ? SW'(1) :
         ((cfg_i.src_w > SW'(bids_pkg::MaxSrcW)) ? SW'(bids_pkg::MaxSrcW) : cfg_i.src_w);
    h  = (cfg_i.src_h == '0) ? SW'(1) :
         ((cfg_i.src_h > SW'(bids_pkg::SrcRowLimit)) ? SW'(bids_pkg::SrcRowLimit) : cfg_i.src_h);
    dw = (cfg_i.dst_w == '0) ? DW'(1) :
         ((cfg_i.dst_w > DW'(bids_pkg::MaxDestDim)) ? DW'(bids_pkg::MaxDestDim) : cfg_i.dst_w);
    dh = (cfg_i.dst_h == '0) ? DW'(1) :
         ((cfg_i.dst_h > DW'(bids_pkg::MaxDestDim)) ? DW'(bids_pkg::MaxDestDim) : cfg_i.dst_h);
  end

  // counters as seen by this item, frame start clears them
  always_comb begin
    scol_e = fs_q ? '0 : scol_q;
    srow_e = fs_q ? '0 : srow_q;
    dcol_e = fs_q ? '0 : dcol_q;
    drow_e = fs_q ? '0 : drow_q;
    xpos_e = fs_q ? '0 : xpos_q;
    ypos_e = fs_q ? '0 : ypos_q;
    oidx_e = fs_q ? '0 : oidx_q;
  end

  always_comb begin
    col  = ({1'b0, scol_e} < w) ? scol_e : ColW'(w - SW'(1));
    row  = ({1'b0, srow_e} < h) ? srow_e : RowW'(h - SW'(1));
    dcol = ({1'b0, dcol_e} < dw) ? dcol_e : DColW'(dw - DW'(1));

    // sample split, saturating at the last column or row
    if (xpos_e[31:16] >= 16'(w - SW'(1))) begin
      x0 = ColW'(w - SW'(1));
      fx = '0;
    end else begin
      x0 = xpos_e[16 +: ColW];
      fx = xpos_e[15:0];
    end
    x1 = ((SW'(x0) + SW'(1)) < w) ? x0 + ColW'(1) : ColW'(w - SW'(1));

    if (ypos_e[31:16] >= 16'(h - SW'(1))) begin
      y0 = RowW'(h - SW'(1));
      fy = '0;
    end else begin
      y0 = ypos_e[16 +: RowW];
      fy = ypos_e[15:0];
    end
    y1 = ((SW'(y0) + SW'(1)) < h) ? y0 + RowW'(1) : RowW'(h - SW'(1));

    trig    = (drow_e < DRowW'(dh)) && ((row > y1) || ((row == y1) && (col >= x1)));
    last    = (drow_e == DRowW'(dh - DW'(1))) && (DW'(dcol) == dw - DW'(1));
    row_end = (SW'(col) >= w - SW'(1));
    xsum    = {1'b0, xpos_e} + (PosW + 1)'(cfg_i.x_step);
    ysum    = {1'b0, ypos_e} + (PosW + 1)'(cfg_i.y_step);
  end

  assign sts_o.trig = trig;

  // capture and counter update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q <= '0;
      srow_q <= '0;
      dcol_q <= '0;
      drow_q <= '0;
      xpos_q <= '0;
      ypos_q <= '0;
      oidx_q <= '0;
      bank_q <= 1'b0;
      fs_q   <= 1'b0;
    end else if (cmd_i.capture) begin
      fs_q <= frame_start_i;
    end else if (cmd_i.step) begin
      fs_q   <= 1'b0;
      dcol_q <= dcol_e;
      drow_q <= drow_e;
      xpos_q <= xpos_e;
      ypos_q <= ypos_e;
      oidx_q <= oidx_e;
      if (trig) begin
        oidx_q <= oidx_e + IdxW'(1);
        if ((DW'(dcol) + DW'(1)) >= dw) begin
          dcol_q <= '0;
          xpos_q <= '0;
          drow_q <= drow_e + DRowW'(1);
          ypos_q <= ysum[PosW] ? '1 : ysum[PosW-1:0];
        end else begin
          dcol_q <= dcol + DColW'(1);
          xpos_q <= xsum[PosW] ? '1 : xsum[PosW-1:0];
        end
      end
      if (row_end) begin
        scol_q <= '0;
        srow_q <= ((SW'(row) + SW'(1)) < h) ? row + RowW'(1) : RowW'(h - SW'(1));
        bank_q <= ~bank_q;
      end else begin
        scol_q <= col + ColW'(1);
        srow_q <= row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= pixel_i;
    end
    if (cmd_i.step) begin
      x0_lt_q  <= (x0 < col);
      x0_eq_q  <= (x0 == col);
      x1_lt_q  <= (x1 < col);
      x1_eq_q  <= (x1 == col);
      top_up_q <= (y1 > y0);
      bank_r_q <= bank_q;
      fx_q     <= fx;
      fy_q     <= fy;
      idx_q    <= oidx_e;
      last_q   <= last;
    end
  end

  // bank 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (!bank_q) begin
        mem0[col] <= pix_q;
      end
      rd00_q <= mem0[x0];
      rd01_q <= mem0[x1];
    end
  end

  // bank 1
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (bank_q) begin
        mem1[col] <= pix_q;
      end
      rd10_q <= mem1[x0];
      rd11_q <= mem1[x1];
    end
  end

  // current row from the written bank up to this column, older row beyond it
  always_comb begin
    l0   = bank_r_q ? rd10_q : rd00_q;
    l1   = bank_r_q ? rd11_q : rd01_q;
    u0   = bank_r_q ? rd00_q : rd10_q;
    u1   = bank_r_q ? rd01_q : rd11_q;
    low0 = x0_lt_q ? l0 : (x0_eq_q ? pix_q : u0);
    low1 = x1_lt_q ? l1 : (x1_eq_q ? pix_q : u1);
    top0 = top_up_q ? u0 : low0;
    top1 = top_up_q ? u1 : low1;
  end

  always_comb begin
    n_d   = NW'((v_q + bids_pkg::NormHalf) >> 17);
    qprod = VW'(n_d) * VW'(bids_pkg::Recip255);
    r     = 24'(n_q) - 24'({q_q, 8'd0} - {8'd0, q_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mulx) begin
      t_q <= 24'(25'(top0) * 25'(bids_pkg::FracOne - 17'(fx_q)) + 25'(top1) * 25'(fx_q));
      b_q <= 24'(25'(low0) * 25'(bids_pkg::FracOne - 17'(fx_q)) + 25'(low1) * 25'(fx_q));
    end
    if (cmd_i.muly0) begin
      p_q <= VW'(t_q) * VW'(bids_pkg::FracOne - 17'(fy_q));
    end
    if (cmd_i.muly1) begin
      v_q <= p_q + VW'(b_q) * VW'(fy_q);
    end
    if (cmd_i.div0) begin
      n_q <= n_d;
      q_q <= qprod[39:24];
    end
    if (cmd_i.div1) begin
      pixel_norm_o <= (r >= 24'd255) ? q_q + 16'd1 : q_q;
      dest_index_o <= idx_q;
      frame_last_o <= last_q;
    end
  end

endmodule
